@@ hdl/wscfd_pkg.sv @@
`default_nettype none

package wscfd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_STOP    = 3'd5
  } phase_t;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Message types
  localparam logic [1:0] MSG_NONE = 2'd0;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [23:0] MAX_MESSAGE_RESET = 24'h80_0000;
  localparam int          QUEUE_DEPTH       = 4;

  // One classified beat on its way from the parser to the output stage
  typedef struct packed {
    logic [1:0] kind;
    logic       has_byte;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       last;
    logic [1:0] message_type;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/websocket_client_frame_decoder.sv @@
// WebSocket client frame decoder.
// Input channel: one stream byte per beat on in_valid / in_stall / stream_byte.
// Output channel: at most one result beat per input byte on out_valid / out_stall
// with kind, has_byte, payload_byte, last and message_type. Header, length and
// mask bytes normally give no result; payload bytes of data, ping and the first
// two of close give one each; errors give a single kind 3 beat.
// Configuration: cfg_we writes cfg_wdata into the 24-bit message size limit.
// Throughput: one byte per cycle while in_stall is low. The parser classifies
// each byte in the cycle it is taken; a result then passes queue and output register.
// A small queue (QueueDepth beats) sits between parser and output register, so
// in_stall rises only when that queue is full while the receiver stalls.
// Reset (rst, synchronous): parser waits for the first header byte, no message
// is open, the limit returns to 8 MiB, queue and output register are emptied.
// After an error or a finished close the parser drops every byte until reset.
`default_nettype none

module websocket_client_frame_decoder #(
  parameter int QueueDepth = wscfd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic             has_byte,
  output logic [7:0]       payload_byte,
  output logic             last,
  output logic [1:0]       message_type
);

  logic              push;
  logic              pop;
  logic              full;
  logic              head_valid;
  wscfd_pkg::entry_t entry;
  wscfd_pkg::entry_t head;

  assign in_stall = full;

  wscfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .entry       (entry)
  );

  wscfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .full       (full),
    .not_empty  (head_valid),
    .head       (head)
  );

  wscfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .has_byte     (has_byte),
    .payload_byte (payload_byte),
    .last         (last),
    .message_type (message_type)
  );

endmodule

`default_nettype wire

@@ hdl/wscfd_front.sv @@
`default_nettype none

module wscfd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [7:0]        stream_byte,
  input  wire logic              cfg_we,
  input  wire logic [23:0]       cfg_wdata,
  output logic                   push,
  output wscfd_pkg::entry_t      entry
);

  wscfd_pkg::phase_t phase, phase_next;

  logic [23:0] max_message_bytes;
  logic        frame_final;
  logic [3:0]  frame_opcode;
  logic [3:0]  length_bytes_left;
  logic [63:0] frame_length;
  logic [31:0] mask_key;
  logic [1:0]  mask_position;
  logic [1:0]  close_bytes_sent;
  logic [1:0]  message_kind;
  logic [23:0] message_length;
  logic [23:0] payload_left;

  logic        take;
  logic [3:0]  op;
  logic        op_ok;
  logic        is_data_op;
  logic        hdr_masked;
  logic [6:0]  len7;
  logic        len_ext;
  logic [3:0]  lbl_dec;
  logic [63:0] cand_length;
  logic        length_check;
  logic [24:0] sum_length;
  logic        length_fail;
  logic        mask_done;
  logic        zero_payload;
  logic [23:0] left_dec;
  logic        payload_end;
  logic [1:0]  close_inc;
  logic        close_last;
  logic [7:0]  key_byte;
  logic        res_valid;
  wscfd_pkg::entry_t res;

  assign take = in_valid && !in_stall;

  // Decode the current byte
  assign op    = stream_byte[3:0];
  assign op_ok = (op == wscfd_pkg::OP_CONT && message_kind != wscfd_pkg::MSG_NONE) ||
                 ((op == wscfd_pkg::OP_TEXT || op == wscfd_pkg::OP_BINARY) &&
                  message_kind == wscfd_pkg::MSG_NONE) ||
                 op == wscfd_pkg::OP_CLOSE || op == wscfd_pkg::OP_PING ||
                 op == wscfd_pkg::OP_PONG;
  assign is_data_op = (frame_opcode == wscfd_pkg::OP_CONT) ||
                      (frame_opcode == wscfd_pkg::OP_TEXT) ||
                      (frame_opcode == wscfd_pkg::OP_BINARY);
  assign hdr_masked = stream_byte[7];
  assign len7       = stream_byte[6:0];
  assign len_ext    = (len7 == wscfd_pkg::LEN_EXT16) || (len7 == wscfd_pkg::LEN_EXT64);
  assign lbl_dec    = (length_bytes_left == 4'd0) ? 4'd0 : length_bytes_left - 4'd1;

  // Length as it stands after this byte
  assign cand_length = (phase == wscfd_pkg::PH_HDR1) ? {57'd0, len7}
                                                      : {frame_length[55:0], stream_byte};
  assign length_check = ((phase == wscfd_pkg::PH_HDR1) && hdr_masked && !len_ext) ||
                        ((phase == wscfd_pkg::PH_EXTLEN) && lbl_dec == 4'd0);

  // Frame limit, then message limit; the sum only matters once the frame fits in 24 bits
  assign sum_length  = {1'b0, message_length} + {1'b0, cand_length[23:0]};
  assign length_fail = (|cand_length[63:24]) || (cand_length[23:0] > max_message_bytes) ||
                       (sum_length > {1'b0, max_message_bytes});

  assign mask_done    = (phase == wscfd_pkg::PH_MASK) && (mask_position == 2'd3);
  assign zero_payload = (payload_left == 24'd0);
  assign left_dec     = payload_left - 24'd1;
  assign payload_end  = (left_dec == 24'd0);
  assign close_inc    = close_bytes_sent + 2'd1;
  assign close_last   = payload_end || (close_inc >= 2'd2);

  // Pick the mask byte for this payload position
  always_comb begin
    case (mask_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      wscfd_pkg::PH_HDR0: begin
        phase_next = op_ok ? wscfd_pkg::PH_HDR1 : wscfd_pkg::PH_STOP;
      end
      wscfd_pkg::PH_HDR1: begin
        if (!hdr_masked) begin
          phase_next = wscfd_pkg::PH_STOP;
        end else if (len_ext) begin
          phase_next = wscfd_pkg::PH_EXTLEN;
        end else begin
          phase_next = length_fail ? wscfd_pkg::PH_STOP : wscfd_pkg::PH_MASK;
        end
      end
      wscfd_pkg::PH_EXTLEN: begin
        if (length_check) begin
          phase_next = length_fail ? wscfd_pkg::PH_STOP : wscfd_pkg::PH_MASK;
        end
      end
      wscfd_pkg::PH_MASK: begin
        if (mask_done) begin
          if (!zero_payload) begin
            phase_next = wscfd_pkg::PH_PAYLOAD;
          end else if (frame_opcode == wscfd_pkg::OP_CLOSE) begin
            phase_next = wscfd_pkg::PH_STOP;
          end else begin
            phase_next = wscfd_pkg::PH_HDR0;
          end
        end
      end
      wscfd_pkg::PH_PAYLOAD: begin
        if (frame_opcode == wscfd_pkg::OP_CLOSE && close_last) begin
          phase_next = wscfd_pkg::PH_STOP;
        end else if (payload_end) begin
          phase_next = wscfd_pkg::PH_HDR0;
        end
      end
      default: phase_next = wscfd_pkg::PH_STOP;
    endcase
  end

  // Result of this byte
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = wscfd_pkg::KIND_ERROR;
    res.has_byte     = 1'b0;
    res.raw_byte     = stream_byte;
    res.key_byte     = key_byte;
    res.last         = 1'b0;
    res.message_type = wscfd_pkg::MSG_NONE;
    case (phase)
      wscfd_pkg::PH_HDR0: begin
        res_valid = !op_ok;
      end
      wscfd_pkg::PH_HDR1: begin
        res_valid = !hdr_masked || (length_check && length_fail);
      end
      wscfd_pkg::PH_EXTLEN: begin
        res_valid = length_check && length_fail;
      end
      wscfd_pkg::PH_MASK: begin
        if (mask_done && zero_payload) begin
          res.last = 1'b1;
          case (frame_opcode)
            wscfd_pkg::OP_CLOSE: begin
              res_valid = 1'b1;
              res.kind  = wscfd_pkg::KIND_CLOSE;
            end
            wscfd_pkg::OP_PING: begin
              res_valid = 1'b1;
              res.kind  = wscfd_pkg::KIND_PING;
            end
            wscfd_pkg::OP_PONG: begin
              res_valid = 1'b0;
            end
            default: begin
              res_valid        = frame_final;
              res.kind         = wscfd_pkg::KIND_DATA;
              res.message_type = message_kind;
            end
          endcase
        end
      end
      wscfd_pkg::PH_PAYLOAD: begin
        res.has_byte = 1'b1;
        case (frame_opcode)
          wscfd_pkg::OP_CLOSE: begin
            res_valid = 1'b1;
            res.kind  = wscfd_pkg::KIND_CLOSE;
            res.last  = close_last;
          end
          wscfd_pkg::OP_PING: begin
            res_valid = 1'b1;
            res.kind  = wscfd_pkg::KIND_PING;
            res.last  = payload_end;
          end
          wscfd_pkg::OP_PONG: begin
            res_valid = 1'b0;
          end
          default: begin
            res_valid        = 1'b1;
            res.kind         = wscfd_pkg::KIND_DATA;
            res.last         = payload_end && frame_final;
            res.message_type = message_kind;
          end
        endcase
      end
      default: res_valid = 1'b0;
    endcase
  end

  assign push  = take && res_valid;
  assign entry = res;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= wscfd_pkg::MAX_MESSAGE_RESET;
    end else if (cfg_we) begin
      max_message_bytes <= cfg_wdata;
    end
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wscfd_pkg::PH_HDR0;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  // Frame and message bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_final       <= 1'b0;
      frame_opcode      <= wscfd_pkg::OP_CONT;
      length_bytes_left <= 4'd0;
      frame_length      <= 64'd0;
      mask_key          <= 32'd0;
      mask_position     <= 2'd0;
      close_bytes_sent  <= 2'd0;
      message_kind      <= wscfd_pkg::MSG_NONE;
      message_length    <= 24'd0;
      payload_left      <= 24'd0;
    end else if (take) begin
      case (phase)
        wscfd_pkg::PH_HDR0: begin
          frame_final  <= stream_byte[7];
          frame_opcode <= op;
          if (op_ok && (op == wscfd_pkg::OP_TEXT || op == wscfd_pkg::OP_BINARY)) begin
            message_kind   <= op[1:0];
            message_length <= 24'd0;
          end
        end
        wscfd_pkg::PH_HDR1, wscfd_pkg::PH_EXTLEN: begin
          if (phase == wscfd_pkg::PH_HDR1 && len_ext) begin
            length_bytes_left <= (len7 == wscfd_pkg::LEN_EXT16) ? wscfd_pkg::EXT16_BYTES
                                                               : wscfd_pkg::EXT64_BYTES;
            frame_length      <= 64'd0;
          end else begin
            if (phase == wscfd_pkg::PH_EXTLEN) begin
              length_bytes_left <= lbl_dec;
            end
            frame_length <= cand_length;
          end
          // Open the mask phase once the length passes
          if (length_check && !length_fail) begin
            if (is_data_op) begin
              message_length <= sum_length[23:0];
            end
            mask_key      <= 32'd0;
            mask_position <= 2'd0;
            payload_left  <= cand_length[23:0];
          end
        end
        wscfd_pkg::PH_MASK: begin
          mask_key      <= {mask_key[23:0], stream_byte};
          mask_position <= mask_position + 2'd1;
          if (mask_done) begin
            close_bytes_sent <= 2'd0;
            if (zero_payload && is_data_op && frame_final) begin
              message_kind   <= wscfd_pkg::MSG_NONE;
              message_length <= 24'd0;
            end
          end
        end
        wscfd_pkg::PH_PAYLOAD: begin
          mask_position <= mask_position + 2'd1;
          payload_left  <= left_dec;
          if (frame_opcode == wscfd_pkg::OP_CLOSE) begin
            close_bytes_sent <= close_inc;
          end
          if (is_data_op && payload_end && frame_final) begin
            message_kind   <= wscfd_pkg::MSG_NONE;
            message_length <= 24'd0;
          end
        end
        default: begin
          frame_final <= frame_final;
        end
      endcase
    end
  end

  // An error beat always leaves the parser stopped
  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    (push && entry.kind == wscfd_pkg::KIND_ERROR) |=> (phase == wscfd_pkg::PH_STOP))
    else $error("parser not stopped after error beat");

  // A stopped parser stays stopped and stays silent
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == wscfd_pkg::PH_STOP) |=> (phase == wscfd_pkg::PH_STOP) && !push)
    else $error("parser left stop or produced a beat");

  // Payload only runs with bytes left to count
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == wscfd_pkg::PH_PAYLOAD) |-> (payload_left != 24'd0))
    else $error("payload phase with zero bytes left");

endmodule

`default_nettype wire

@@ hdl/wscfd_queue.sv @@
`default_nettype none

module wscfd_queue #(
  parameter int Depth = wscfd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire wscfd_pkg::entry_t push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output wscfd_pkg::entry_t      head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  wscfd_pkg::entry_t slots [Depth];

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store incoming beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ hdl/wscfd_back.sv @@
`default_nettype none

module wscfd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire wscfd_pkg::entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic                   has_byte,
  output logic [7:0]             payload_byte,
  output logic                   last,
  output logic [1:0]             message_type
);

  logic [7:0] unmasked;

  // Load a new beat whenever the output register is empty or being taken
  assign pop      = head_valid && (!out_valid || !out_stall);
  assign unmasked = head.has_byte ? (head.raw_byte ^ head.key_byte) : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      kind         <= head.kind;
      has_byte     <= head.has_byte;
      payload_byte <= unmasked;
      last         <= head.last;
      message_type <= head.message_type;
    end
  end

  a_zero_without_byte: assert property (@(posedge clk) disable iff (rst)
    pop |=> (has_byte || payload_byte == 8'd0))
    else $error("payload byte set on a beat without a byte");

endmodule

`default_nettype wire
